[src/assert_macros.svh]
// Assertion helpers shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define WST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define WST_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

[src/wst_pkg.sv]
`default_nettype none
package wst_pkg;

  localparam int POS_BITS = 16;
  localparam int LEN_BITS = POS_BITS + 1;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ESC_ADDR = 3'd0;

  localparam int OUT_FIELD_BITS = POS_BITS + LEN_BITS + 2;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                has;
    logic                token_valid;
    logic [POS_BITS-1:0] token_start;
    logic [LEN_BITS-1:0] token_length;
    logic                quoted;
    logic                line_break_after;
    logic                at_end;
  } res_t;

endpackage
`default_nettype wire

[src/whitespace_token_scanner.sv]
// Channel | Direction | Words
// in_     | slave     | one text byte per word, tlast on the final byte
// out_    | master    | at most one token result per input word
// cfg_    | APB slave | escape_enable at byte address 0
//
// One input word is taken per cycle when the result side keeps up.
// A result passes through the input register, then the result register.
// The token state is updated by a single pass of compare logic between the two.
// Reset is synchronous and active low; escape_enable resets to zero.
// A held result stalls input only when the next word also produces a result.
`default_nettype none
`include "assert_macros.svh"
module whitespace_token_scanner import wst_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [7:0]                in_tdata,   // byte_value
  input  wire logic                      in_tlast,   // is_last
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // token_start, token_length, quoted, line_break_after, zero fill
  output logic [OUT_TDATA_BITS-1:0]      out_tdata,
  output logic                           out_tuser,  // token_valid
  output logic                           out_tlast,  // at_end
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic      [CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                           cfg_pready
);

  logic       esc_en;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       adv;
  res_t       res;

  logic                      out_vld_r;
  logic [OUT_TDATA_BITS-1:0] out_data_r;
  logic                      out_tv_r;
  logic                      out_end_r;

  logic out_empty;
  logic out_quoted;
  logic out_break;

  wst_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .esc_en  (esc_en)
  );

  wst_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .byte_val (in_byte_r),
    .last     (in_last_r),
    .esc_en   (esc_en),
    .res      (res)
  );

  assign adv       = in_vld_r && (!res.has || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && res.has) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.has) begin
      out_data_r <= {{(OUT_TDATA_BITS-OUT_FIELD_BITS){1'b0}}, res.line_break_after,
                     res.quoted, res.token_length, res.token_start};
      out_tv_r   <= res.token_valid;
      out_end_r  <= res.at_end;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_tv_r;
  assign out_tlast  = out_end_r;

  assign out_empty  = out_vld_r && !out_tv_r;
  assign out_quoted = out_data_r[POS_BITS+LEN_BITS];
  assign out_break  = out_data_r[POS_BITS+LEN_BITS+1];

  `WST_ASSERT(a_empty_only_at_end, !out_empty || out_end_r, "empty result not at end")
  `WST_ASSERT(a_empty_is_zero, !out_empty || (out_data_r == '0), "empty result has data")
  `WST_ASSERT(a_quoted_no_break, !(out_vld_r && out_quoted) || !out_break, "quoted with break")

endmodule
`default_nettype wire

[src/wst_cfg.sv]
`default_nettype none
module wst_cfg import wst_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output logic                          esc_en
);

  logic esc_en_r;
  logic esc_en_nxt;

  always_comb begin
    esc_en_nxt = esc_en_r;
    if (psel && penable && pwrite && (paddr == REG_ESC_ADDR)) begin
      esc_en_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b0;
    end else begin
      esc_en_r <= esc_en_nxt;
    end
  end

  assign prdata = (paddr == REG_ESC_ADDR) ? {{(CFG_DATA_BITS-1){1'b0}}, esc_en_r}
                                          : {CFG_DATA_BITS{1'b0}};
  assign pready = 1'b1;
  assign esc_en = esc_en_r;

endmodule
`default_nettype wire

[src/wst_core.sv]
`default_nettype none
`include "assert_macros.svh"
module wst_core import wst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] byte_val,
  input  wire logic       last,
  input  wire logic       esc_en,
  output res_t            res
);

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic                open_r, open_nxt;
  logic                inq_r, inq_nxt;
  logic                esc_r, esc_nxt;
  logic                qsingle_r, qsingle_nxt;

  logic       emit;
  logic       clr;
  logic [7:0] qc;

  always_comb begin
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    open_nxt    = open_r;
    inq_nxt     = inq_r;
    esc_nxt     = esc_r;
    qsingle_nxt = qsingle_r;
    emit        = 1'b0;
    clr         = 1'b0;
    qc          = qsingle_r ? CH_SQUOTE : CH_DQUOTE;
    res         = '0;

    if (open_r && inq_r) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (esc_en && (byte_val == CH_BACKSLASH)) begin
        esc_nxt = 1'b1;
      end else if (byte_val == qc) begin
        emit       = 1'b1;
        clr        = 1'b1;
        res.quoted = 1'b1;
      end
    end else if (byte_val > CH_SPACE) begin
      if (!open_r) begin
        open_nxt  = 1'b1;
        start_nxt = pos_r;
        if ((byte_val == CH_DQUOTE) || (byte_val == CH_SQUOTE)) begin
          inq_nxt     = 1'b1;
          qsingle_nxt = (byte_val == CH_SQUOTE);
        end
      end
    end else if (open_r) begin
      emit                 = 1'b1;
      clr                  = 1'b1;
      res.line_break_after = (byte_val == CH_CR) || (byte_val == CH_LF);
    end

    if (emit) begin
      res.token_valid  = 1'b1;
      res.token_start  = start_r;
      res.token_length = {1'b0, pos_r} - {1'b0, start_r};
    end

    if (clr) begin
      start_nxt   = '0;
      open_nxt    = 1'b0;
      inq_nxt     = 1'b0;
      esc_nxt     = 1'b0;
      qsingle_nxt = 1'b0;
    end

    // The last byte of a buffer always closes whatever token is still open.
    if (last && !emit && open_nxt) begin
      res.token_valid  = 1'b1;
      res.token_start  = start_nxt;
      res.token_length = {1'b0, pos_r} + LEN_BITS'(1) - {1'b0, start_nxt};
      res.quoted       = inq_nxt;
    end

    res.has    = emit || last;
    res.at_end = last;

    if (last) begin
      pos_nxt     = '0;
      start_nxt   = '0;
      open_nxt    = 1'b0;
      inq_nxt     = 1'b0;
      esc_nxt     = 1'b0;
      qsingle_nxt = 1'b0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      start_r   <= '0;
      open_r    <= 1'b0;
      inq_r     <= 1'b0;
      esc_r     <= 1'b0;
      qsingle_r <= 1'b0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      open_r    <= open_nxt;
      inq_r     <= inq_nxt;
      esc_r     <= esc_nxt;
      qsingle_r <= qsingle_nxt;
    end
  end

  `WST_ASSERT(a_quote_needs_token, !inq_r || open_r, "quote state without open token")
  `WST_ASSERT(a_escape_needs_quote, !esc_r || inq_r, "escape pending outside quotes")
  `WST_ASSERT_NEXT(a_last_resets_pos, step && last, pos_r == '0, "position not reset")

endmodule
`default_nettype wire
